// ===== hdl/cgc_pkg.sv =====
package cgc_pkg;

    // Configuration register file
    localparam int GRID_REG_BITS  = 7;
    localparam int COS_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam cfg_index_t REG_GRID_WIDTH  = 2'd0;
    localparam cfg_index_t REG_GRID_HEIGHT = 2'd1;
    localparam cfg_index_t REG_COS_LIMIT   = 2'd2;

    localparam logic [GRID_REG_BITS-1:0] GRID_WIDTH_RESET  = 7'd6;
    localparam logic [GRID_REG_BITS-1:0] GRID_HEIGHT_RESET = 7'd4;
    localparam logic [COS_BITS-1:0]      COS_LIMIT_RESET   = 16'd64622;

    // Grid dimension compares run at this width (covers maxima up to 511)
    localparam int DIM_BITS = 9;

    // Frame point counter, saturating
    localparam int                   SEEN_BITS = 13;
    localparam logic [SEEN_BITS-1:0] SEEN_MAX  = 13'd8191;

    // Limb width of the shared multiplier
    localparam int LIMB_BITS = 32;

    // Handshake from the triple test unit back to the frame sequencer
    typedef struct packed {
        logic done;
        logic bends;
    } triple_status_t;

endpackage

// ===== hdl/cgc_channels.sv =====
interface cgc_point_if #(
    parameter int COORD_BITS = 20
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  frame_last;

    modport source (output valid, output point_x, output point_y, output frame_last,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input frame_last,
                    output ready);
endinterface

interface cgc_result_if;
    logic valid;
    logic ready;
    logic grid_ok;
    logic count_mismatch;
    logic bend_found;

    modport source (output valid, output grid_ok, output count_mismatch, output bend_found,
                    input ready);
    modport sink   (input valid, input grid_ok, input count_mismatch, input bend_found,
                    output ready);
endinterface

// ===== hdl/cgc_ram.sv =====
module cgc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cgc_triple_unit.sv =====
module cgc_triple_unit #(
    parameter int COORD_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2*COORD_BITS-1:0]       p0,
    input  logic [2*COORD_BITS-1:0]       p1,
    input  logic [2*COORD_BITS-1:0]       p2,
    input  logic [cgc_pkg::COS_BITS-1:0]  cos_limit_squared,
    output cgc_pkg::triple_status_t       status
);
    import cgc_pkg::*;

    // Lengths and dot magnitude, scaled length product, full compare width
    localparam int PB  = 2*COORD_BITS + 1;
    localparam int TB  = PB + COS_BITS;
    localparam int AW  = 2*PB + COS_BITS;
    localparam int NL  = (TB + LIMB_BITS - 1) / LIMB_BITS;
    localparam int LCB = $clog2(NL);
    localparam int OPW = NL * LIMB_BITS;
    localparam int PRW = 2 * LIMB_BITS;

    typedef enum logic [2:0] {
        PH_IDLE, PH_DOT, PH_LEN1, PH_LEN2, PH_MAG, PH_TPROD, PH_RPROD, PH_CMP
    } phase_t;

    phase_t                   phase_reg;
    logic [LCB-1:0]           i_reg;
    logic [LCB-1:0]           j_reg;
    logic [AW-1:0]            acc_reg;
    logic [COORD_BITS-1:0]    ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic                     sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic [PB-1:0]            mag_reg, len1_reg, len2_reg;
    logic [TB-1:0]            t_reg;
    logic [AW-1:0]            lhs_reg;
    logic [COS_BITS-1:0]      cls_reg;

    logic [COORD_BITS:0]      dx1, dy1, dx2, dy2;
    logic [OPW-1:0]           op_a, op_b;
    logic                     negate;
    logic                     wide_phase;
    logic [LIMB_BITS-1:0]     a_limb, b_limb;
    logic [PRW-1:0]           prod;
    logic [LCB:0]             shift_cnt;
    logic [AW-1:0]            term, acc_base, acc_next, mag_full;
    logic                     first_step, last_step;

    function automatic logic [COORD_BITS:0] coord_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
        return {1'b0, a} - {1'b0, b};
    endfunction

    function automatic logic [COORD_BITS-1:0] diff_abs(input logic [COORD_BITS:0] d);
        logic [COORD_BITS:0] m;
        m = d[COORD_BITS] ? ((COORD_BITS+1)'(0) - d) : d;
        return m[COORD_BITS-1:0];
    endfunction

    // Difference vectors of the incoming triple
    assign dx1 = coord_diff(p1[COORD_BITS-1:0], p0[COORD_BITS-1:0]);
    assign dy1 = coord_diff(p1[2*COORD_BITS-1:COORD_BITS], p0[2*COORD_BITS-1:COORD_BITS]);
    assign dx2 = coord_diff(p2[COORD_BITS-1:0], p1[COORD_BITS-1:0]);
    assign dy2 = coord_diff(p2[2*COORD_BITS-1:COORD_BITS], p1[2*COORD_BITS-1:COORD_BITS]);

    // Select multiplier operands for the current phase
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        negate = 1'b0;
        case (phase_reg)
            PH_DOT:
            begin
                if (j_reg == '0)
                begin
                    op_a   = OPW'(ax1_reg);
                    op_b   = OPW'(ax2_reg);
                    negate = sx1_reg ^ sx2_reg;
                end
                else
                begin
                    op_a   = OPW'(ay1_reg);
                    op_b   = OPW'(ay2_reg);
                    negate = sy1_reg ^ sy2_reg;
                end
            end
            PH_LEN1:
            begin
                op_a = (j_reg == '0) ? OPW'(ax1_reg) : OPW'(ay1_reg);
                op_b = op_a;
            end
            PH_LEN2:
            begin
                op_a = (j_reg == '0) ? OPW'(ax2_reg) : OPW'(ay2_reg);
                op_b = op_a;
            end
            PH_MAG:
            begin
                op_a = OPW'(mag_reg);
                op_b = OPW'(mag_reg);
            end
            PH_TPROD:
            begin
                op_a = OPW'(cls_reg);
                op_b = OPW'(len1_reg);
            end
            PH_RPROD:
            begin
                op_a = OPW'(t_reg);
                op_b = OPW'(len2_reg);
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // Shared limb multiplier and wide accumulator
    assign wide_phase = (phase_reg == PH_MAG) || (phase_reg == PH_TPROD)
                        || (phase_reg == PH_RPROD);
    assign a_limb     = op_a[i_reg*LIMB_BITS +: LIMB_BITS];
    assign b_limb     = wide_phase ? op_b[j_reg*LIMB_BITS +: LIMB_BITS] : op_b[LIMB_BITS-1:0];
    assign prod       = PRW'(a_limb) * PRW'(b_limb);
    assign shift_cnt  = wide_phase ? ((LCB+1)'(i_reg) + (LCB+1)'(j_reg)) : '0;
    assign term       = AW'(prod) << (LIMB_BITS * shift_cnt);
    assign first_step = (i_reg == '0) && (j_reg == '0);
    assign acc_base   = first_step ? '0 : acc_reg;
    assign acc_next   = negate ? (acc_base - term) : (acc_base + term);
    assign mag_full   = acc_next[AW-1] ? (AW'(0) - acc_next) : acc_next;
    assign last_step  = wide_phase ? ((i_reg == LCB'(NL-1)) && (j_reg == LCB'(NL-1)))
                                   : (j_reg == LCB'(1));

    // Sequence the products of one triple
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            acc_reg   <= '0;
            ax1_reg   <= '0;
            ay1_reg   <= '0;
            ax2_reg   <= '0;
            ay2_reg   <= '0;
            sx1_reg   <= 1'b0;
            sy1_reg   <= 1'b0;
            sx2_reg   <= 1'b0;
            sy2_reg   <= 1'b0;
            mag_reg   <= '0;
            len1_reg  <= '0;
            len2_reg  <= '0;
            t_reg     <= '0;
            lhs_reg   <= '0;
            cls_reg   <= '0;
        end
        else if (start)
        begin
            // Latch the difference vectors and threshold
            ax1_reg   <= diff_abs(dx1);
            ay1_reg   <= diff_abs(dy1);
            ax2_reg   <= diff_abs(dx2);
            ay2_reg   <= diff_abs(dy2);
            sx1_reg   <= dx1[COORD_BITS];
            sy1_reg   <= dy1[COORD_BITS];
            sx2_reg   <= dx2[COORD_BITS];
            sy2_reg   <= dy2[COORD_BITS];
            cls_reg   <= cos_limit_squared;
            i_reg     <= '0;
            j_reg     <= '0;
            phase_reg <= PH_DOT;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE, PH_CMP:
                begin
                    phase_reg <= PH_IDLE;
                end
                PH_DOT, PH_LEN1, PH_LEN2, PH_MAG, PH_TPROD, PH_RPROD:
                begin
                    acc_reg <= acc_next;
                    // Advance the limb indices
                    if (last_step)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                    end
                    else if (wide_phase && (j_reg == LCB'(NL-1)))
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + LCB'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + LCB'(1);
                    end
                    // Store the finished quantity and move on
                    if (last_step)
                    begin
                        unique case (phase_reg)
                            PH_DOT:
                            begin
                                mag_reg   <= mag_full[PB-1:0];
                                phase_reg <= PH_LEN1;
                            end
                            PH_LEN1:
                            begin
                                len1_reg  <= acc_next[PB-1:0];
                                phase_reg <= PH_LEN2;
                            end
                            PH_LEN2:
                            begin
                                len2_reg  <= acc_next[PB-1:0];
                                phase_reg <= PH_MAG;
                            end
                            PH_MAG:
                            begin
                                lhs_reg   <= {acc_next[2*PB-1:0], {COS_BITS{1'b0}}};
                                phase_reg <= PH_TPROD;
                            end
                            PH_TPROD:
                            begin
                                t_reg     <= acc_next[TB-1:0];
                                phase_reg <= PH_RPROD;
                            end
                            default:
                            begin
                                phase_reg <= PH_CMP;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // Bend when the scaled squared dot falls short; zero-length steps pass
    assign status.done  = (phase_reg == PH_CMP);
    assign status.bends = (len1_reg != '0) && (len2_reg != '0) && (lhs_reg < acc_reg);

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (phase_reg == PH_IDLE || phase_reg == PH_CMP))
        else $error("triple start while unit busy");

    a_start_resets_count: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (phase_reg == PH_DOT && i_reg == '0 && j_reg == '0))
        else $error("triple did not begin at first product");

    a_zero_len_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (status.done && (len1_reg == '0 || len2_reg == '0)) |-> !status.bends)
        else $error("zero-length step reported as bend");

endmodule

// ===== hdl/corner_grid_collinearity_check.sv =====
// Corner grid collinearity check.
// point_in carries one detected corner per item (point_x, point_y, frame_last) in
// raster order; result_out carries one item per frame (grid_ok, count_mismatch,
// bend_found), given after the corner that has frame_last set. Both channels use
// valid/ready; an item moves when both are high.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 grid width,
// 1 grid height, 2 squared cosine limit in Q0.16); the user is to write only while
// the block is idle, and the block itself does not enforce it. Each corner triggers
// k triple tests (0, 1 or 2, one along the row and one along the column), run in
// turn on the single 32x32 multiplier that forms every product of both tests; the
// work per test grows with NL, the number of 32-bit limbs of the widest product
// operand (NL = 2 at 20 coordinate bits).
// Two line buffers hold the corners of the two rows above, written once per corner
// in the grid. The result is registered in S_EMIT, after the last corner finishes.
// Reset returns registers to their defaults and clears the frame state; the line
// buffers are not cleared. A result not taken is held; the next corner is still
// accepted, and only the following frame result waits for the output to drain.
module corner_grid_collinearity_check #(
    parameter int MAX_GRID_WIDTH  = 64,
    parameter int MAX_GRID_HEIGHT = 64,
    parameter int COORD_BITS      = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    cgc_point_if.sink           point_in,
    cgc_result_if.source        result_out,
    input  logic                cfg_we,
    input  cgc_pkg::cfg_index_t cfg_index,
    input  cgc_pkg::cfg_data_t  cfg_data
);
    import cgc_pkg::*;

    localparam int PW       = 2 * COORD_BITS;
    localparam int COL_BITS = $clog2(MAX_GRID_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_GRID_HEIGHT + 1);
    localparam int PROD_BITS = 2 * GRID_REG_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_ROW, S_COL, S_FINISH, S_EMIT
    } state_t;

    state_t                    state_reg;
    logic [GRID_REG_BITS-1:0]  grid_width_reg, grid_height_reg;
    logic [COS_BITS-1:0]       cos_limit_reg;
    logic [PW-1:0]             point_reg, prev0_reg, prev1_reg;
    logic                      last_reg, in_grid_reg;
    logic [COL_BITS-1:0]       col_reg;
    logic [ROW_BITS-1:0]       row_reg;
    logic [SEEN_BITS-1:0]      seen_reg, seen_next;
    logic                      bend_reg;
    logic                      out_valid_reg, out_ok_reg, out_mismatch_reg, out_bend_reg;

    logic [DIM_BITS-1:0]       w_eff, h_eff, col_plus;
    logic                      in_grid, col_wrap, row_go, col_go, use_col;
    logic [PROD_BITS-1:0]      expected;
    logic                      mismatch, emit_free, accept;
    logic [PW-1:0]             one_rdata, two_rdata;
    logic                      line_we;
    logic                      tu_start;
    logic [PW-1:0]             tu_p0, tu_p1, tu_p2;
    triple_status_t            tu_status;

    // Clamp the grid to the buffer size for positioning
    assign w_eff = (DIM_BITS'(grid_width_reg) > DIM_BITS'(MAX_GRID_WIDTH))
                   ? DIM_BITS'(MAX_GRID_WIDTH) : DIM_BITS'(grid_width_reg);
    assign h_eff = (DIM_BITS'(grid_height_reg) > DIM_BITS'(MAX_GRID_HEIGHT))
                   ? DIM_BITS'(MAX_GRID_HEIGHT) : DIM_BITS'(grid_height_reg);
    assign in_grid  = (w_eff != '0) && (DIM_BITS'(row_reg) < h_eff)
                      && (DIM_BITS'(col_reg) < w_eff);
    assign col_plus = DIM_BITS'(col_reg) + DIM_BITS'(1);
    assign col_wrap = (col_plus >= w_eff);
    assign seen_next = (seen_reg < SEEN_MAX) ? (seen_reg + SEEN_BITS'(1)) : seen_reg;

    // Point count against the register product
    assign expected = PROD_BITS'(grid_width_reg) * PROD_BITS'(grid_height_reg);
    assign mismatch = (PROD_BITS'(seen_reg) != expected);

    assign accept    = point_in.valid && point_in.ready;
    assign emit_free = !out_valid_reg || result_out.ready;

    // Which triple tests this corner takes part in
    assign row_go  = in_grid_reg && (col_reg >= COL_BITS'(2));
    assign col_go  = in_grid_reg && (row_reg >= ROW_BITS'(2));
    assign use_col = (state_reg == S_ROW) || ((state_reg == S_READ) && !row_go);

    assign tu_start = ((state_reg == S_READ) && (row_go || col_go))
                      || ((state_reg == S_ROW) && tu_status.done && col_go);
    assign tu_p0 = use_col ? two_rdata : prev0_reg;
    assign tu_p1 = use_col ? one_rdata : prev1_reg;
    assign tu_p2 = point_reg;

    assign line_we = (state_reg == S_FINISH) && in_grid_reg;

    cgc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_line_one (
        .clk   (clk),
        .we    (line_we),
        .waddr (col_reg),
        .wdata (point_reg),
        .raddr (col_reg),
        .rdata (one_rdata)
    );

    cgc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_line_two (
        .clk   (clk),
        .we    (line_we),
        .waddr (col_reg),
        .wdata (one_rdata),
        .raddr (col_reg),
        .rdata (two_rdata)
    );

    cgc_triple_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_triple (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (tu_start),
        .p0                (tu_p0),
        .p1                (tu_p1),
        .p2                (tu_p2),
        .cos_limit_squared (cos_limit_reg),
        .status            (tu_status)
    );

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
            cos_limit_reg   <= COS_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GRID_REG_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GRID_REG_BITS-1:0];
                REG_COS_LIMIT:   cos_limit_reg   <= cfg_data[COS_BITS-1:0];
                default:         cos_limit_reg   <= cos_limit_reg;
            endcase
        end
    end

    // Frame sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            point_reg        <= '0;
            prev0_reg        <= '0;
            prev1_reg        <= '0;
            last_reg         <= 1'b0;
            in_grid_reg      <= 1'b0;
            col_reg          <= '0;
            row_reg          <= '0;
            seen_reg         <= '0;
            bend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_ok_reg       <= 1'b0;
            out_mismatch_reg <= 1'b0;
            out_bend_reg     <= 1'b0;
        end
        else
        begin
            // Drop the result once taken
            if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        point_reg   <= {point_in.point_y, point_in.point_x};
                        last_reg    <= point_in.frame_last;
                        in_grid_reg <= in_grid;
                        seen_reg    <= seen_next;
                        state_reg   <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (row_go)
                    begin
                        state_reg <= S_ROW;
                    end
                    else if (col_go)
                    begin
                        state_reg <= S_COL;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_ROW:
                begin
                    if (tu_status.done)
                    begin
                        bend_reg  <= bend_reg | tu_status.bends;
                        state_reg <= col_go ? S_COL : S_FINISH;
                    end
                end
                S_COL:
                begin
                    if (tu_status.done)
                    begin
                        bend_reg  <= bend_reg | tu_status.bends;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    // Advance the grid position
                    if (in_grid_reg)
                    begin
                        if (col_wrap)
                        begin
                            col_reg   <= '0;
                            row_reg   <= row_reg + ROW_BITS'(1);
                            prev0_reg <= '0;
                            prev1_reg <= '0;
                        end
                        else
                        begin
                            col_reg   <= col_reg + COL_BITS'(1);
                            prev0_reg <= prev1_reg;
                            prev1_reg <= point_reg;
                        end
                    end
                    state_reg <= last_reg ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (emit_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_ok_reg       <= !mismatch && !bend_reg;
                        out_mismatch_reg <= mismatch;
                        out_bend_reg     <= bend_reg;
                        prev0_reg        <= '0;
                        prev1_reg        <= '0;
                        col_reg          <= '0;
                        row_reg          <= '0;
                        seen_reg         <= '0;
                        bend_reg         <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign point_in.ready            = (state_reg == S_IDLE);
    assign result_out.valid          = out_valid_reg;
    assign result_out.grid_ok        = out_ok_reg;
    assign result_out.count_mismatch = out_mismatch_reg;
    assign result_out.bend_found     = out_bend_reg;

    a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.grid_ok
                              == !(result_out.count_mismatch || result_out.bend_found)))
        else $error("grid_ok disagrees with the failure flags");

    a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && emit_free)
        |=> (seen_reg == '0 && !bend_reg && col_reg == '0 && row_reg == '0))
        else $error("frame state not cleared after result");

endmodule
